FILE: hw/rtl/mdfs_pkg.sv
package mdfs_pkg;

  // operation codes carried in the input tuser
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_SOLVE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_GRID_ROWS = 3'd0;
  localparam logic [2:0] REG_GRID_COLS = 3'd1;
  localparam logic [2:0] REG_START_ROW = 3'd2;
  localparam logic [2:0] REG_START_COL = 3'd3;
  localparam logic [2:0] REG_GOAL_ROW  = 3'd4;
  localparam logic [2:0] REG_GOAL_COL  = 3'd5;

  // move directions as stored on the path stack
  localparam logic [2:0] DIR_NONE  = 3'd0;
  localparam logic [2:0] DIR_UP    = 3'd1;
  localparam logic [2:0] DIR_RIGHT = 3'd2;
  localparam logic [2:0] DIR_DOWN  = 3'd3;
  localparam logic [2:0] DIR_LEFT  = 3'd4;

  // cell store codes
  localparam logic [1:0] CELL_OPEN = 2'b00;
  localparam logic [1:0] CELL_WALL = 2'b01;
  localparam logic [1:0] CELL_SEEN = 2'b10;

  typedef struct packed {
    logic [6:0] grid_rows;
    logic [6:0] grid_cols;
    logic [5:0] start_row;
    logic [5:0] start_col;
    logic [5:0] goal_row;
    logic [5:0] goal_col;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [5:0]  row;
    logic [5:0]  col;
    logic        wall;
    logic [11:0] idx;
  } cmd_t;

  typedef struct packed {
    logic        found;
    logic [12:0] path_length;
    logic        entry_valid;
    logic [5:0]  step_row;
    logic [5:0]  step_col;
    logic [2:0]  step_dir;
  } res_t;

endpackage

FILE: hw/rtl/maze_dfs_path_finder.sv
// Grid maze solver, depth-first search over a cell store and a position stack.
// Input stream: tuser selects the request (cell write, solve, path read),
// tdata carries cell row/col, wall bit and path index. Every request gives
// exactly one result on the output stream: found flag and path length always,
// plus one path entry (row, col, direction taken) for a read inside the path.
// Configuration: cfg_valid_i/cfg_ready_o, register index and data; always ready.
// The user must write it only while no request is in flight; not enforced here.
// Request flow: a cell write or a path read is one access to the cell store or
// the path stack. A solve first marks and pushes the entrance, then forces the
// goal open; each search step checks for the goal, tries the directions in turn
// with a cell-store read per in-grid neighbour, and then pushes the neighbour or
// pops the stack, which re-reads the new top entry from the path stack.
// The result sits in an output register: a new request is taken while it waits,
// but the next result is held inside until the receiver takes the previous one.
// Reset: after rst_ni rises the cell store is cleared, one cell a cycle, over all
// MAX_ROWS*MAX_COLS cells (4096 at the defaults); no request is taken then.
// Visited marks persist between solves until the cells are written again.
module maze_dfs_path_finder #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [5:0] cell_row, [11:6] cell_col, [12] is_wall, [24:13] path_index
  input  logic [31:0] s_axis_tdata,
  // [1:0] operation
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] found, [13:1] path_length, [19:14] step_row, [25:20] step_col,
  // [28:26] step_dir
  output logic [31:0] m_axis_tdata,
  // [0] entry_valid
  output logic [0:0]  m_axis_tuser,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [6:0]  cfg_data_i
);
  import mdfs_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_rows <= 7'd64;
      cfg_q.grid_cols <= 7'd64;
      cfg_q.start_row <= 6'd0;
      cfg_q.start_col <= 6'd0;
      cfg_q.goal_row  <= 6'd0;
      cfg_q.goal_col  <= 6'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_GRID_ROWS: cfg_q.grid_rows <= cfg_data_i;
        REG_GRID_COLS: cfg_q.grid_cols <= cfg_data_i;
        REG_START_ROW: cfg_q.start_row <= cfg_data_i[5:0];
        REG_START_COL: cfg_q.start_col <= cfg_data_i[5:0];
        REG_GOAL_ROW:  cfg_q.goal_row  <= cfg_data_i[5:0];
        REG_GOAL_COL:  cfg_q.goal_col  <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  cmd_t cmd;
  assign cmd.op   = s_axis_tuser;
  assign cmd.row  = s_axis_tdata[5:0];
  assign cmd.col  = s_axis_tdata[11:6];
  assign cmd.wall = s_axis_tdata[12];
  assign cmd.idx  = s_axis_tdata[24:13];

  logic eng_res_valid, res_ready;
  res_t eng_res;

  mdfs_engine #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (s_axis_tvalid),
    .cmd_ready_o (s_axis_tready),
    .cmd_i       (cmd),
    .res_valid_o (eng_res_valid),
    .res_ready_i (res_ready),
    .res_o       (eng_res)
  );

  // output register
  logic m_valid_q, m_valid_d;
  res_t m_res_q;

  assign res_ready = !m_valid_q || m_axis_tready;

  always_comb begin
    m_valid_d = m_valid_q;
    if (eng_res_valid && res_ready) m_valid_d = 1'b1;
    else if (m_axis_tready)         m_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_valid_q <= 1'b0;
    else         m_valid_q <= m_valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (eng_res_valid && res_ready) m_res_q <= eng_res;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {3'd0, m_res_q.step_dir, m_res_q.step_col, m_res_q.step_row,
                          m_res_q.path_length, m_res_q.found};
  assign m_axis_tuser  = m_res_q.entry_valid;

  a_entry_needs_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && m_res_q.entry_valid |-> m_res_q.found && m_res_q.path_length != 13'd0)
    else $error("path entry returned without a found path");

  a_found_has_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && m_res_q.found |-> m_res_q.path_length != 13'd0)
    else $error("found path reported with zero length");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_res_valid && res_ready |=> m_valid_q)
    else $error("result handed over but output register empty");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && !m_axis_tready |=> m_valid_q && $stable(m_res_q))
    else $error("pending result overwritten or lost");

endmodule

FILE: hw/rtl/mdfs_engine.sv
module mdfs_engine #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mdfs_pkg::cfg_t  cfg_i,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  mdfs_pkg::cmd_t  cmd_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output mdfs_pkg::res_t  res_o
);
  import mdfs_pkg::*;

  localparam int NCELLS = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = $clog2(NCELLS);
  localparam int CNT_W  = $clog2(NCELLS + 1);
  localparam int RW     = $clog2(MAX_ROWS);
  localparam int CW     = $clog2(MAX_COLS);
  localparam int RL_W   = $clog2(MAX_ROWS + 1);
  localparam int CL_W   = $clog2(MAX_COLS + 1);
  localparam int SE_W   = RW + CW + 3;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_WRITE = 4'd2;
  localparam logic [3:0] S_READ  = 4'd3;
  localparam logic [3:0] S_SOLVE = 4'd4;
  localparam logic [3:0] S_GOAL  = 4'd5;
  localparam logic [3:0] S_CHECK = 4'd6;
  localparam logic [3:0] S_PROBE = 4'd7;
  localparam logic [3:0] S_EVAL  = 4'd8;
  localparam logic [3:0] S_PUSH  = 4'd9;
  localparam logic [3:0] S_POP   = 4'd10;
  localparam logic [3:0] S_POPLD = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [RW-1:0] r,
                                                  input logic [CW-1:0] c);
    return ADDR_W'(32'(r) * MAX_COLS + 32'(c));
  endfunction

  // memories
  logic [1:0]      cell_mem [NCELLS];
  logic [SE_W-1:0] stack_mem [NCELLS];

  logic              cw_en, cr_en, sw_en, sr_en;
  logic [ADDR_W-1:0] cw_addr, cr_addr, sw_addr, sr_addr;
  logic [1:0]        cw_data, cell_rdata_q;
  logic [SE_W-1:0]   sw_data, st_rdata_q;

  always_ff @(posedge clk_i) begin
    if (cw_en) cell_mem[cw_addr] <= cw_data;
    if (cr_en) cell_rdata_q <= cell_mem[cr_addr];
  end

  always_ff @(posedge clk_i) begin
    if (sw_en) stack_mem[sw_addr] <= sw_data;
    if (sr_en) st_rdata_q <= stack_mem[sr_addr];
  end

  // control and datapath registers
  logic [3:0]        state_q, state_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              found_q, found_d;
  logic              rd_valid_q, rd_valid_d;
  cmd_t              cmd_q, cmd_d;
  logic [RW-1:0]     top_r_q, top_r_d, nb_r_q, nb_r_d;
  logic [CW-1:0]     top_c_q, top_c_d, nb_c_q, nb_c_d;
  logic [2:0]        dir_q, dir_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_q      <= '0;
      count_q    <= '0;
      found_q    <= 1'b0;
      rd_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      count_q    <= count_d;
      found_q    <= found_d;
      rd_valid_q <= rd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    top_r_q <= top_r_d;
    top_c_q <= top_c_d;
    nb_r_q  <= nb_r_d;
    nb_c_q  <= nb_c_d;
    dir_q   <= dir_d;
  end

  // clamped grid size
  logic [RL_W-1:0] rows_lim;
  logic [CL_W-1:0] cols_lim;
  always_comb begin
    if (cfg_i.grid_rows == 7'd0)             rows_lim = RL_W'(1);
    else if (32'(cfg_i.grid_rows) > MAX_ROWS) rows_lim = RL_W'(MAX_ROWS);
    else                                     rows_lim = RL_W'(cfg_i.grid_rows);
    if (cfg_i.grid_cols == 7'd0)             cols_lim = CL_W'(1);
    else if (32'(cfg_i.grid_cols) > MAX_COLS) cols_lim = CL_W'(MAX_COLS);
    else                                     cols_lim = CL_W'(cfg_i.grid_cols);
  end

  logic ends_in_grid;
  assign ends_in_grid = (32'(cfg_i.start_row) < 32'(rows_lim)) &&
                        (32'(cfg_i.start_col) < 32'(cols_lim)) &&
                        (32'(cfg_i.goal_row)  < 32'(rows_lim)) &&
                        (32'(cfg_i.goal_col)  < 32'(cols_lim));

  logic at_goal;
  assign at_goal = (32'(top_r_q) == 32'(cfg_i.goal_row)) &&
                   (32'(top_c_q) == 32'(cfg_i.goal_col));

  // neighbour of the stack top in the direction under test
  logic          nb_ok;
  logic [RW-1:0] nr;
  logic [CW-1:0] nc;
  logic [RW:0]   nr_inc;
  logic [CW:0]   nc_inc;
  always_comb begin
    nr     = top_r_q;
    nc     = top_c_q;
    nr_inc = {1'b0, top_r_q} + (RW + 1)'(1);
    nc_inc = {1'b0, top_c_q} + (CW + 1)'(1);
    unique case (dir_q)
      DIR_UP: begin
        nb_ok = top_r_q != '0;
        nr    = top_r_q - RW'(1);
      end
      DIR_RIGHT: begin
        nb_ok = 32'(nc_inc) < 32'(cols_lim);
        nc    = nc_inc[CW-1:0];
      end
      DIR_DOWN: begin
        nb_ok = 32'(nr_inc) < 32'(rows_lim);
        nr    = nr_inc[RW-1:0];
      end
      DIR_LEFT: begin
        nb_ok = top_c_q != '0;
        nc    = top_c_q - CW'(1);
      end
      default: nb_ok = 1'b0;
    endcase
  end

  logic [CNT_W-1:0] cnt_m1, cnt_m2, len;
  assign cnt_m1 = count_q - CNT_W'(1);
  assign cnt_m2 = count_q - CNT_W'(2);
  assign len    = found_q ? count_q : '0;

  logic [RW-1:0] rd_r;
  logic [CW-1:0] rd_c;
  logic [2:0]    rd_d;
  assign rd_r = st_rdata_q[3+CW +: RW];
  assign rd_c = st_rdata_q[3 +: CW];
  assign rd_d = st_rdata_q[2:0];

  assign cmd_ready_o = (state_q == S_IDLE) || (state_q == S_DONE && res_ready_i);
  assign res_valid_o = state_q == S_DONE;

  always_comb begin
    res_o.found       = found_q;
    res_o.path_length = 13'(len);
    res_o.entry_valid = rd_valid_q;
    res_o.step_row    = rd_valid_q ? 6'(rd_r) : 6'd0;
    res_o.step_col    = rd_valid_q ? 6'(rd_c) : 6'd0;
    res_o.step_dir    = rd_valid_q ? rd_d : DIR_NONE;
  end

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    count_d    = count_q;
    found_d    = found_q;
    rd_valid_d = rd_valid_q;
    cmd_d      = cmd_q;
    top_r_d    = top_r_q;
    top_c_d    = top_c_q;
    nb_r_d     = nb_r_q;
    nb_c_d     = nb_c_q;
    dir_d      = dir_q;
    cw_en      = 1'b0;
    cw_addr    = cell_addr(nb_r_q, nb_c_q);
    cw_data    = CELL_SEEN;
    cr_en      = 1'b0;
    cr_addr    = cell_addr(nr, nc);
    sw_en      = 1'b0;
    sw_addr    = cnt_m1[ADDR_W-1:0];
    sw_data    = {top_r_q, top_c_q, dir_q};
    sr_en      = 1'b0;
    sr_addr    = cnt_m2[ADDR_W-1:0];

    unique case (state_q)
      S_CLEAR: begin
        cw_en   = 1'b1;
        cw_addr = clr_q;
        cw_data = CELL_OPEN;
        clr_d   = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(NCELLS - 1)) state_d = S_IDLE;
      end
      S_WRITE: begin
        cw_en   = (32'(cmd_q.row) < MAX_ROWS) && (32'(cmd_q.col) < MAX_COLS);
        cw_addr = cell_addr(RW'(cmd_q.row), CW'(cmd_q.col));
        cw_data = cmd_q.wall ? CELL_WALL : CELL_OPEN;
        state_d = S_DONE;
      end
      S_READ: begin
        rd_valid_d = 32'(cmd_q.idx) < 32'(len);
        sr_en      = 1'b1;
        sr_addr    = ADDR_W'(cmd_q.idx);
        state_d    = S_DONE;
      end
      S_SOLVE: begin
        found_d = 1'b0;
        count_d = '0;
        top_r_d = RW'(cfg_i.start_row);
        top_c_d = CW'(cfg_i.start_col);
        if (ends_in_grid) begin
          cw_en   = 1'b1;
          cw_addr = cell_addr(RW'(cfg_i.start_row), CW'(cfg_i.start_col));
          cw_data = CELL_SEEN;
          sw_en   = 1'b1;
          sw_addr = '0;
          sw_data = {RW'(cfg_i.start_row), CW'(cfg_i.start_col), DIR_NONE};
          state_d = S_GOAL;
        end else begin
          state_d = S_DONE;
        end
      end
      S_GOAL: begin
        // goal forced open after the entrance mark, so it wins when both coincide
        cw_en   = 1'b1;
        cw_addr = cell_addr(RW'(cfg_i.goal_row), CW'(cfg_i.goal_col));
        cw_data = CELL_OPEN;
        count_d = CNT_W'(1);
        state_d = S_CHECK;
      end
      S_CHECK: begin
        dir_d = DIR_UP;
        if (at_goal) begin
          found_d = 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        nb_r_d = nr;
        nb_c_d = nc;
        if (nb_ok) begin
          cr_en   = 1'b1;
          state_d = S_EVAL;
        end else if (dir_q == DIR_LEFT) begin
          state_d = S_POP;
        end else begin
          dir_d = dir_q + 3'd1;
        end
      end
      S_EVAL: begin
        if (cell_rdata_q == CELL_OPEN && 32'(count_q) < NCELLS) begin
          // mark the neighbour and record the move in the current top entry
          cw_en   = 1'b1;
          sw_en   = 1'b1;
          state_d = S_PUSH;
        end else if (dir_q == DIR_LEFT) begin
          state_d = S_POP;
        end else begin
          dir_d   = dir_q + 3'd1;
          state_d = S_PROBE;
        end
      end
      S_PUSH: begin
        sw_en   = 1'b1;
        sw_addr = count_q[ADDR_W-1:0];
        sw_data = {nb_r_q, nb_c_q, DIR_NONE};
        count_d = count_q + CNT_W'(1);
        top_r_d = nb_r_q;
        top_c_d = nb_c_q;
        state_d = S_CHECK;
      end
      S_POP: begin
        count_d = cnt_m1;
        if (count_q == CNT_W'(1)) begin
          state_d = S_DONE;
        end else begin
          sr_en   = 1'b1;
          state_d = S_POPLD;
        end
      end
      S_POPLD: begin
        top_r_d = rd_r;
        top_c_d = rd_c;
        state_d = S_CHECK;
      end
      S_IDLE, S_DONE: begin
        if (state_q == S_DONE && res_ready_i) state_d = S_IDLE;
        if (cmd_valid_i && cmd_ready_o) begin
          cmd_d      = cmd_i;
          rd_valid_d = 1'b0;
          unique case (cmd_i.op)
            OP_WRITE: state_d = S_WRITE;
            OP_SOLVE: state_d = S_SOLVE;
            OP_READ:  state_d = S_READ;
            default:  state_d = S_DONE;
          endcase
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
